FILE: rtl/core/sawas_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sawas_pkg
// Shared codes and types of the stop-and-wait ARQ sender unit.
// ---------------------------------------------------------------------------
package sawas_pkg;

	// input event codes
	localparam logic [1:0] OP_PACKET = 2'd0;
	localparam logic [1:0] OP_ACK    = 2'd1;
	localparam logic [1:0] OP_NACK   = 2'd2;

	// classified command passed from front to back
	typedef enum logic [1:0] {
		CMD_PACKET = 2'd0,
		CMD_ACK    = 2'd1,
		CMD_NACK   = 2'd2
	} cmd_kind_t;

	// result kind codes
	typedef enum logic [1:0] {
		SEND_NEW  = 2'd0,
		SEND_RETX = 2'd1,
		SEND_DROP = 2'd2
	} send_kind_t;

	// sender mode
	typedef enum logic [1:0] {
		MODE_IDLE        = 2'd0,
		MODE_WAIT_EMPTY  = 2'd1,
		MODE_WAIT_QUEUED = 2'd2
	} mode_t;

	// back end sequencer
	typedef enum logic {
		BK_RUN  = 1'b0,
		BK_READ = 1'b1
	} back_state_t;

	// entries of the small queues between the parts
	localparam int unsigned CMD_SLOTS = 2;
	localparam int unsigned RES_SLOTS = 2;

endpackage

FILE: rtl/core/sawas_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sawas_ram
// Generic single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
module sawas_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/sawas_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sawas_front
// Accepts input events, classifies them and holds them in a two-slot
// command queue for the back end. Unused event codes are absorbed here.
// ---------------------------------------------------------------------------
module sawas_front #(
	parameter int LENGTH_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [1:0]             operation,
	input  logic [LENGTH_BITS-1:0] packet_length,
	output logic                   cmd_valid,
	output sawas_pkg::cmd_kind_t   cmd_kind,
	output logic [LENGTH_BITS-1:0] cmd_len,
	input  logic                   cmd_take
);
	import sawas_pkg::*;

	cmd_kind_t              kind_q [CMD_SLOTS];
	logic [LENGTH_BITS-1:0] len_q  [CMD_SLOTS];
	logic                   wr_q;
	logic                   rd_q;
	logic [1:0]             count_q;
	logic                   accept;
	logic                   store;
	cmd_kind_t              kind_d;

	assign full   = (count_q == 2'(CMD_SLOTS));
	assign accept = push && !full;

	// classify the event code
	always_comb begin
		kind_d = CMD_PACKET;
		store  = 1'b0;
		unique case (operation)
			OP_PACKET: begin
				kind_d = CMD_PACKET;
				store  = accept;
			end
			OP_ACK: begin
				kind_d = CMD_ACK;
				store  = accept;
			end
			OP_NACK: begin
				kind_d = CMD_NACK;
				store  = accept;
			end
			default: begin
				store = 1'b0;
			end
		endcase
	end

	// command payload slots
	always_ff @(posedge clk) begin
		if (store) begin
			kind_q[wr_q] <= kind_d;
			len_q[wr_q]  <= packet_length;
		end
	end

	// command queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (store) begin
				wr_q <= !wr_q;
			end
			if (cmd_take) begin
				rd_q <= !rd_q;
			end
			count_q <= count_q + 2'(store) - 2'(cmd_take);
		end
	end

	assign cmd_valid = (count_q != 2'd0);
	assign cmd_kind  = kind_q[rd_q];
	assign cmd_len   = len_q[rd_q];

endmodule

FILE: rtl/core/sawas_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sawas_back
// Carries out commands: sender mode, transmit FIFO over a RAM, outstanding
// packet length, and a two-slot result queue toward the output side.
// ---------------------------------------------------------------------------
module sawas_back #(
	parameter int QUEUE_DEPTH = 16,
	parameter int LENGTH_BITS = 16,
	localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1),
	localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	input  sawas_pkg::cmd_kind_t   cmd_kind,
	input  logic [LENGTH_BITS-1:0] cmd_len,
	output logic                   cmd_take,
	output logic                   empty,
	input  logic                   pop,
	output logic [1:0]             send_kind,
	output logic [LENGTH_BITS-1:0] sent_length,
	output logic [COUNT_W-1:0]     queue_level
);
	import sawas_pkg::*;

	back_state_t            state_q;
	back_state_t            state_d;
	mode_t                  mode_q;
	mode_t                  mode_d;
	logic [LENGTH_BITS-1:0] outst_q;
	logic [PTR_W-1:0]       head_q;
	logic [PTR_W-1:0]       tail_q;
	logic [COUNT_W-1:0]     count_q;
	logic                   fifo_full;
	logic                   ram_we;
	logic                   ram_re;
	logic [LENGTH_BITS-1:0] ram_rdata;
	logic                   set_outst;
	logic                   res_push;
	send_kind_t             res_kind;
	logic [LENGTH_BITS-1:0] res_len;
	logic                   res_room;
	logic                   res_pop;

	// result queue storage
	send_kind_t             rq_kind_q  [RES_SLOTS];
	logic [LENGTH_BITS-1:0] rq_len_q   [RES_SLOTS];
	logic [COUNT_W-1:0]     rq_level_q [RES_SLOTS];
	logic                   rq_wr_q;
	logic                   rq_rd_q;
	logic [1:0]             rq_count_q;

	assign fifo_full = (count_q == COUNT_W'(QUEUE_DEPTH));
	assign res_room  = (rq_count_q != 2'(RES_SLOTS));
	assign res_pop   = pop && !empty;

	// transmit FIFO store
	sawas_ram #(
		.WIDTH (LENGTH_BITS),
		.DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (cmd_len),
		.re    (ram_re),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_RUN: begin
				if (ram_re) begin
					state_d = BK_READ;
				end
			end
			BK_READ: begin
				state_d = BK_RUN;
			end
			default: begin
				state_d = BK_RUN;
			end
		endcase
	end

	// command execution
	always_comb begin
		cmd_take  = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		set_outst = 1'b0;
		res_push  = 1'b0;
		res_kind  = SEND_NEW;
		res_len   = cmd_len;
		mode_d    = mode_q;
		unique case (state_q)
			BK_RUN: begin
				if (cmd_valid && res_room) begin
					cmd_take = 1'b1;
					unique case (cmd_kind)
						CMD_PACKET: begin
							if (mode_q == MODE_IDLE) begin
								res_push  = 1'b1;
								set_outst = 1'b1;
								mode_d    = MODE_WAIT_EMPTY;
							end else if (fifo_full) begin
								res_push = 1'b1;
								res_kind = SEND_DROP;
							end else begin
								ram_we = 1'b1;
								mode_d = MODE_WAIT_QUEUED;
							end
						end
						CMD_ACK: begin
							if (mode_q != MODE_IDLE) begin
								if (count_q == '0) begin
									mode_d = MODE_IDLE;
								end else begin
									ram_re = 1'b1;
								end
							end
						end
						CMD_NACK: begin
							if (mode_q != MODE_IDLE) begin
								res_push = 1'b1;
								res_kind = SEND_RETX;
								res_len  = outst_q;
							end
						end
						default: begin
							cmd_take = 1'b1;
						end
					endcase
				end
			end
			BK_READ: begin
				// next queued packet comes out of the store
				res_push  = 1'b1;
				res_len   = ram_rdata;
				set_outst = 1'b1;
				mode_d    = (count_q == '0) ? MODE_WAIT_EMPTY : MODE_WAIT_QUEUED;
			end
			default: begin
				mode_d = mode_q;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_RUN;
			mode_q  <= MODE_IDLE;
			outst_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			if (set_outst) begin
				outst_q <= res_len;
			end
			if (ram_we) begin
				tail_q <= (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (ram_re) begin
				head_q <= (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			count_q <= count_q + COUNT_W'(ram_we) - COUNT_W'(ram_re);
		end
	end

	// result queue payload
	always_ff @(posedge clk) begin
		if (res_push) begin
			rq_kind_q[rq_wr_q]  <= res_kind;
			rq_len_q[rq_wr_q]   <= res_len;
			rq_level_q[rq_wr_q] <= count_q;
		end
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q    <= 1'b0;
			rq_rd_q    <= 1'b0;
			rq_count_q <= 2'd0;
		end else begin
			if (res_push) begin
				rq_wr_q <= !rq_wr_q;
			end
			if (res_pop) begin
				rq_rd_q <= !rq_rd_q;
			end
			rq_count_q <= rq_count_q + 2'(res_push) - 2'(res_pop);
		end
	end

	assign empty       = (rq_count_q == 2'd0);
	assign send_kind   = rq_kind_q[rq_rd_q];
	assign sent_length = rq_len_q[rq_rd_q];
	assign queue_level = rq_level_q[rq_rd_q];

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(QUEUE_DEPTH))
		else $error("fifo count above depth");
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_IDLE) |-> (count_q == '0))
		else $error("idle sender with queued packets");
	a_read_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_READ) |=> (state_q == BK_RUN))
		else $error("read state held");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> res_room || (state_q == BK_READ && $past(res_room)))
		else $error("result queue overflow");
	a_rq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rq_count_q <= 2'(RES_SLOTS))
		else $error("result queue count above slots");

endmodule

FILE: rtl/core/stop_and_wait_arq_sender_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stop_and_wait_arq_sender_unit
// Sender side of a stop-and-wait ARQ link with a transmit FIFO.
// ---------------------------------------------------------------------------
// channel   direction  handshake            payload
// events    in         push / full          operation, packet_length
// results   out        empty / pop          send_kind, sent_length, queue_level
//
// a packet, NACK or idle ACK is handled in BK_RUN alone; an ACK that pulls a
// queued packet also passes BK_READ for the registered read of the FIFO RAM.
// a two-slot command queue decouples input from the back end, and a two-slot
// result queue lets events keep flowing while a result waits to be popped.
// reset is asynchronous and clears all control state; no clearing pass.
// ---------------------------------------------------------------------------
module stop_and_wait_arq_sender_unit #(
	parameter int QUEUE_DEPTH = 16,
	parameter int LENGTH_BITS = 16,
	localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [1:0]             operation,
	input  logic [LENGTH_BITS-1:0] packet_length,
	output logic                   empty,
	input  logic                   pop,
	output logic [1:0]             send_kind,
	output logic [LENGTH_BITS-1:0] sent_length,
	output logic [COUNT_W-1:0]     queue_level
);
	import sawas_pkg::*;

	logic                   cmd_valid;
	cmd_kind_t              cmd_kind;
	logic [LENGTH_BITS-1:0] cmd_len;
	logic                   cmd_take;

	// event intake and classification
	sawas_front #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.operation     (operation),
		.packet_length (packet_length),
		.cmd_valid     (cmd_valid),
		.cmd_kind      (cmd_kind),
		.cmd_len       (cmd_len),
		.cmd_take      (cmd_take)
	);

	// protocol execution and results
	sawas_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_kind    (cmd_kind),
		.cmd_len     (cmd_len),
		.cmd_take    (cmd_take),
		.empty       (empty),
		.pop         (pop),
		.send_kind   (send_kind),
		.sent_length (sent_length),
		.queue_level (queue_level)
	);

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stop-and-wait ARQ sender unit. Events are
// pushed in bursts with random gaps, and results are popped on a stall
// pattern of their own. A cycle-free model of the sender predicts each
// result, and every popped result is checked field by field against it.
// ---------------------------------------------------------------------------
module tb_top;
	import sawas_pkg::*;

	localparam int DEPTH      = 16;
	localparam int LEN_W      = 16;
	localparam int LEVEL_W    = $clog2(DEPTH + 1);
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_EVENTS = 720;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int TAIL_CYCLES   = 10;

	typedef struct {
		send_kind_t         kind;
		logic [LEN_W-1:0]   length;
		logic [LEVEL_W-1:0] level;
	} send_rec_t;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [1:0]         operation;
	logic [LEN_W-1:0]   packet_length;
	logic               empty;
	logic               pop;
	logic [1:0]         send_kind;
	logic [LEN_W-1:0]   sent_length;
	logic [LEVEL_W-1:0] queue_level;

	// model of the sender
	mode_t            m_mode;
	logic [LEN_W-1:0] m_outstanding;
	logic [LEN_W-1:0] m_fifo [DEPTH];
	int unsigned      m_head;
	int unsigned      m_tail;
	int unsigned      m_count;

	send_rec_t sends_expected [$];

	int errors;
	int items_sent;
	int results_checked;
	int drops_seen;
	int retx_seen;
	int burst_left;
	int hold_req;

	stop_and_wait_arq_sender_unit #(
		.QUEUE_DEPTH(DEPTH),
		.LENGTH_BITS(LEN_W)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.operation    (operation),
		.packet_length(packet_length),
		.empty        (empty),
		.pop          (pop),
		.send_kind    (send_kind),
		.sent_length  (sent_length),
		.queue_level  (queue_level)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// known values from time zero
	initial begin
		arst_n        = 1'b0;
		push          = 1'b0;
		operation     = OP_PACKET;
		packet_length = '0;
		pop           = 1'b0;
		errors        = 0;
		items_sent    = 0;
		results_checked = 0;
		drops_seen    = 0;
		retx_seen     = 0;
		burst_left    = 0;
		hold_req      = 0;
		m_mode        = MODE_IDLE;
		m_outstanding = '0;
		m_head        = 0;
		m_tail        = 0;
		m_count       = 0;
	end

	// queue a predicted result
	function automatic void note_send(send_kind_t kind, logic [LEN_W-1:0] len);
		send_rec_t rec;
		rec.kind   = kind;
		rec.length = len;
		rec.level  = LEVEL_W'(m_count);
		sends_expected.push_back(rec);
	endfunction

	// advance the model by one event; returns 1 unless the event is ignored
	function automatic bit predict_transmit(logic [1:0] op, logic [LEN_W-1:0] len);
		case (op)
			OP_PACKET: begin
				if (m_mode == MODE_IDLE) begin
					m_outstanding = len;
					m_mode = MODE_WAIT_EMPTY;
					note_send(SEND_NEW, len);
				end else if (m_count >= DEPTH) begin
					note_send(SEND_DROP, len);
				end else begin
					m_fifo[m_tail] = len;
					m_tail = (m_tail == DEPTH - 1) ? 0 : m_tail + 1;
					m_count++;
					m_mode = MODE_WAIT_QUEUED;
				end
				return 1'b1;
			end
			OP_ACK: begin
				if (m_mode == MODE_IDLE)
					return 1'b0;
				if (m_count == 0) begin
					m_mode = MODE_IDLE;
					return 1'b1;
				end
				m_outstanding = m_fifo[m_head];
				m_head = (m_head == DEPTH - 1) ? 0 : m_head + 1;
				m_count--;
				m_mode = (m_count == 0) ? MODE_WAIT_EMPTY : MODE_WAIT_QUEUED;
				note_send(SEND_NEW, m_outstanding);
				return 1'b1;
			end
			OP_NACK: begin
				if (m_mode == MODE_IDLE)
					return 1'b0;
				note_send(SEND_RETX, m_outstanding);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// push one item, with a possible random gap at the start of each burst
	task automatic send_event(input logic [1:0] op, input logic [LEN_W-1:0] len,
			output bit effective);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0)
				gap = $urandom_range(1, 8);
		end
		burst_left--;
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push          <= 1'b1;
		operation     <= op;
		packet_length <= len;
		@(posedge clk);
		while (full)
			@(posedge clk);
		items_sent++;
		effective = predict_transmit(op, len);
	endtask

	task automatic send_quiet(input logic [1:0] op, input logic [LEN_W-1:0] len);
		bit eff;
		send_event(op, len, eff);
	endtask

	// length with the edges favored
	function automatic logic [LEN_W-1:0] pick_length();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return '1;
		return LEN_W'($urandom_range(0, (1 << LEN_W) - 1));
	endfunction

	// result checker and receiver stall pattern
	initial begin
		send_rec_t exp_rec;
		int hold_left;
		int phase_left;
		int pattern;
		int tick;
		hold_left  = 0;
		phase_left = 0;
		pattern    = 0;
		tick       = 0;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (sends_expected.size() == 0) begin
					errors++;
					$display("%0t: unexpected result kind %0d length %0d level %0d",
						$time, send_kind, sent_length, queue_level);
				end else begin
					exp_rec = sends_expected.pop_front();
					results_checked++;
					if (exp_rec.kind == SEND_DROP)
						drops_seen++;
					if (exp_rec.kind == SEND_RETX)
						retx_seen++;
					if (send_kind !== exp_rec.kind) begin
						errors++;
						$display("%0t: send_kind expected %0d actual %0d",
							$time, exp_rec.kind, send_kind);
					end
					if (sent_length !== exp_rec.length) begin
						errors++;
						$display("%0t: sent_length expected %0d actual %0d",
							$time, exp_rec.length, sent_length);
					end
					if (queue_level !== exp_rec.level) begin
						errors++;
						$display("%0t: queue_level expected %0d actual %0d",
							$time, exp_rec.level, queue_level);
					end
				end
			end
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (phase_left == 0) begin
				phase_left = $urandom_range(32, 128);
				pattern    = $urandom_range(0, 3);
			end
			phase_left--;
			tick++;
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				case (pattern)
					0: pop <= 1'b1;
					1: pop <= ($urandom_range(0, 1) == 1);
					2: pop <= ((tick % 4) == 0);
					default: pop <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// ack and nack with nothing outstanding, and the unused code
	task automatic test_idle_events();
		send_quiet(OP_ACK, '1);
		send_quiet(OP_NACK, 16'h5a5a);
		send_quiet(OP_UNUSED, 16'ha5a5);
	endtask

	// new packet, retransmission of the outstanding packet, ack handoff
	task automatic test_send_and_retransmit();
		send_quiet(OP_PACKET, '0);
		send_quiet(OP_NACK, '1);
		send_quiet(OP_PACKET, '1);
		send_quiet(OP_NACK, 16'h1234);
		send_quiet(OP_UNUSED, 16'h1234);
		send_quiet(OP_ACK, '0);
		send_quiet(OP_NACK, '0);
		send_quiet(OP_ACK, '1);
		send_quiet(OP_ACK, '0);
	endtask

	// receiver holds off while the fifo fills and packets are dropped
	task automatic test_fill_and_drop();
		hold_req = 400;
		for (int i = 0; i < DEPTH + 15; i++)
			send_quiet(OP_PACKET, pick_length());
		send_quiet(OP_NACK, pick_length());
		for (int i = 0; i < DEPTH + 1; i++)
			send_quiet(OP_ACK, pick_length());
	endtask

	// random traffic, phases biased toward filling or draining the fifo
	task automatic test_random_traffic();
		int done;
		int phase_left;
		int fill_bias;
		int sel;
		logic [1:0] op;
		bit eff;
		done       = 0;
		phase_left = 0;
		fill_bias  = 50;
		while (done < RANDOM_EVENTS) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(20, 80);
				fill_bias  = $urandom_range(20, 80);
			end
			phase_left--;
			sel = $urandom_range(0, 99);
			if (sel < 5)
				op = OP_UNUSED;
			else if (sel < 20)
				op = OP_NACK;
			else if ($urandom_range(0, 99) < fill_bias)
				op = OP_PACKET;
			else
				op = OP_ACK;
			send_event(op, pick_length(), eff);
			if (eff)
				done++;
		end
	endtask

	// main sequence
	initial begin
		int waited;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_idle_events();
		test_send_and_retransmit();
		test_fill_and_drop();
		test_random_traffic();
		@(negedge clk);
		push <= 1'b0;
		waited = 0;
		while (sends_expected.size() > 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sends_expected.size() != 0) begin
			errors++;
			$display("%0t: %0d expected results never arrived",
				$time, sends_expected.size());
		end
		$display("run covered %0d events and %0d checked results", items_sent,
			results_checked);
		$display("including %0d drops on a full fifo and %0d retransmissions",
			drops_seen, retx_seen);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
